@@ src/contour_right_angle_corner_detect_assert.svh @@
// ----------------------------------------------------------------------------
// contour right-angle corner detect assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef CONTOUR_RIGHT_ANGLE_CORNER_DETECT_ASSERT_SVH
`define CONTOUR_RIGHT_ANGLE_CORNER_DETECT_ASSERT_SVH

// same-cycle implication
`define CRADC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRADC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cradc_pkg.sv @@
// ----------------------------------------------------------------------------
// cradc_pkg
// shared widths and types of the contour corner detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cradc_pkg;

    localparam int COORD_BITS   = 12;
    localparam int ANG_BITS     = 16;
    localparam int TOL_BITS     = 7;

    localparam logic signed [ANG_BITS-1:0] RIGHT_Q8 = 16'sd23040;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic [COORD_BITS-1:0] bx;
        logic [COORD_BITS-1:0] by;
    } t_seg_req;

    typedef struct packed {
        logic                       done;
        logic signed [ANG_BITS-1:0] angle;
    } t_seg_rsp;

endpackage

@@ src/contour_right_angle_corner_detect.sv @@
// ----------------------------------------------------------------------------
// contour_right_angle_corner_detect
// right-angle corner detection over the points of a closed contour
// first point: stored; second point: runs the 16-iteration arctangent for the first segment
// later points: start, 16 iterations, rounding, angle capture, turn check
// a corner beat is offered the cycle after its turn check
// end marker: follows the last point; with 3 or more points, after closing segment and checks
// result beats leave one a cycle while taken; a held beat stalls the input when another result is due
// synchronous active-low reset: empty contour, tolerance 20, no result pending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module contour_right_angle_corner_detect
    import cradc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pt_valid,
    output logic                  o_pt_ready,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic                  i_last_point,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [COORD_BITS-1:0] o_corner_x,
    output logic [COORD_BITS-1:0] o_corner_y,
    output logic                  o_is_corner,
    output logic                  o_end_of_contour,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [TOL_BITS-1:0]   i_cfg_angle_tolerance
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEG   = 3'd1;
    localparam logic [2:0] S_CHK1  = 3'd2;
    localparam logic [2:0] S_CLOSE = 3'd3;
    localparam logic [2:0] S_CHK2  = 3'd4;
    localparam logic [2:0] S_CHK3  = 3'd5;
    localparam logic [2:0] S_MARK  = 3'd6;

    localparam logic [TOL_BITS-1:0] TOL_RESET = 7'd20;
    localparam logic [TOL_BITS-1:0] RIGHT_DEG = 7'd90;

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;
    localparam logic [1:0] SEEN_FULL = 2'd3;

    function automatic logic is_right(input logic signed [ANG_BITS-1:0] a1,
                                      input logic signed [ANG_BITS-1:0] a2,
                                      input logic [TOL_BITS-1:0]        tol);
        logic signed [ANG_BITS:0] d;
        logic [ANG_BITS:0]        ad;
        logic [TOL_BITS-1:0]      lo_deg;
        logic [TOL_BITS:0]        hi_deg;
        logic                     lo_ok;
        logic                     hi_ok;
        d      = {a2[ANG_BITS-1], a2} - {a1[ANG_BITS-1], a1};
        ad     = d[ANG_BITS] ? (ANG_BITS+1)'(-d) : (ANG_BITS+1)'(d);
        lo_deg = RIGHT_DEG - tol;
        hi_deg = {1'b0, RIGHT_DEG} + {1'b0, tol};
        lo_ok  = (tol > RIGHT_DEG) || (ad >= {2'b00, lo_deg, 8'h00});
        hi_ok  = ad <= {1'b0, hi_deg, 8'h00};
        return lo_ok && hi_ok;
    endfunction

    logic [2:0]                 r_state, n_state;
    logic [1:0]                 r_seen, n_seen;
    logic [TOL_BITS-1:0]        r_tol, n_tol;
    logic [COORD_BITS-1:0]      r_first_x, n_first_x, r_first_y, n_first_y;
    logic [COORD_BITS-1:0]      r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic [COORD_BITS-1:0]      r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic                       r_cur_last, n_cur_last;
    logic signed [ANG_BITS-1:0] r_prev_ang, n_prev_ang;
    logic signed [ANG_BITS-1:0] r_first_ang, n_first_ang;
    logic signed [ANG_BITS-1:0] r_seg_ang, n_seg_ang;
    logic signed [ANG_BITS-1:0] r_close_ang, n_close_ang;
    logic                       r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0]      r_out_x, n_out_x, r_out_y, n_out_y;
    logic                       r_out_corner, n_out_corner;
    logic                       r_out_end, n_out_end;

    logic                       w_out_free;
    logic                       w_turn;
    logic signed [ANG_BITS-1:0] w_a1, w_a2;
    t_seg_req                   w_req;
    t_seg_rsp                   w_rsp;

    cradc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_out_free = !r_out_valid || i_res_ready;

    // turn operands per check step
    always_comb begin
        unique case (r_state)
            S_CHK2: begin
                w_a1 = r_prev_ang;
                w_a2 = r_close_ang;
            end
            S_CHK3: begin
                w_a1 = r_close_ang;
                w_a2 = r_first_ang;
            end
            default: begin
                w_a1 = r_prev_ang;
                w_a2 = r_seg_ang;
            end
        endcase
        w_turn = is_right(w_a1, w_a2, r_tol);
    end

    always_comb begin
        n_state      = r_state;
        n_seen       = r_seen;
        n_tol        = r_tol;
        n_first_x    = r_first_x;
        n_first_y    = r_first_y;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_cur_last   = r_cur_last;
        n_prev_ang   = r_prev_ang;
        n_first_ang  = r_first_ang;
        n_seg_ang    = r_seg_ang;
        n_close_ang  = r_close_ang;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_corner = r_out_corner;
        n_out_end    = r_out_end;

        // closing segment runs from the current point back to the first
        w_req.start = 1'b0;
        if (r_state == S_CHK1) begin
            w_req.ax = r_cur_x;
            w_req.ay = r_cur_y;
            w_req.bx = r_first_x;
            w_req.by = r_first_y;
        end else begin
            w_req.ax = r_prev_x;
            w_req.ay = r_prev_y;
            w_req.bx = i_point_x;
            w_req.by = i_point_y;
        end

        if (i_cfg_valid) begin
            n_tol = i_cfg_angle_tolerance;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_pt_valid) begin
                    n_cur_x    = i_point_x;
                    n_cur_y    = i_point_y;
                    n_cur_last = i_last_point;
                    if (r_seen == SEEN_NONE) begin
                        n_first_x = i_point_x;
                        n_first_y = i_point_y;
                        n_prev_x  = i_point_x;
                        n_prev_y  = i_point_y;
                        n_seen    = SEEN_ONE;
                        n_state   = i_last_point ? S_MARK : S_IDLE;
                    end else begin
                        w_req.start = 1'b1;
                        n_state     = S_SEG;
                    end
                end
            end
            S_SEG: begin
                if (w_rsp.done) begin
                    n_seg_ang = w_rsp.angle;
                    if (r_seen == SEEN_ONE) begin
                        n_first_ang = w_rsp.angle;
                        n_prev_ang  = w_rsp.angle;
                        n_prev_x    = r_cur_x;
                        n_prev_y    = r_cur_y;
                        n_seen      = SEEN_TWO;
                        n_state     = r_cur_last ? S_MARK : S_IDLE;
                    end else begin
                        n_state = S_CHK1;
                    end
                end
            end
            S_CHK1: begin
                if (!w_turn || w_out_free) begin
                    if (w_turn) begin
                        n_out_valid  = 1'b1;
                        n_out_x      = r_prev_x;
                        n_out_y      = r_prev_y;
                        n_out_corner = 1'b1;
                        n_out_end    = 1'b0;
                    end
                    n_prev_ang = r_seg_ang;
                    n_prev_x   = r_cur_x;
                    n_prev_y   = r_cur_y;
                    n_seen     = SEEN_FULL;
                    if (r_cur_last) begin
                        w_req.start = 1'b1;
                        n_state     = S_CLOSE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CLOSE: begin
                if (w_rsp.done) begin
                    n_close_ang = w_rsp.angle;
                    n_state     = S_CHK2;
                end
            end
            S_CHK2: begin
                if (!w_turn || w_out_free) begin
                    if (w_turn) begin
                        n_out_valid  = 1'b1;
                        n_out_x      = r_cur_x;
                        n_out_y      = r_cur_y;
                        n_out_corner = 1'b1;
                        n_out_end    = 1'b0;
                    end
                    n_state = S_CHK3;
                end
            end
            S_CHK3: begin
                if (!w_turn || w_out_free) begin
                    if (w_turn) begin
                        n_out_valid  = 1'b1;
                        n_out_x      = r_first_x;
                        n_out_y      = r_first_y;
                        n_out_corner = 1'b1;
                        n_out_end    = 1'b0;
                    end
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_x      = '0;
                    n_out_y      = '0;
                    n_out_corner = 1'b0;
                    n_out_end    = 1'b1;
                    n_first_x    = '0;
                    n_first_y    = '0;
                    n_prev_x     = '0;
                    n_prev_y     = '0;
                    n_prev_ang   = '0;
                    n_first_ang  = '0;
                    n_seen       = SEEN_NONE;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= SEEN_NONE;
            r_tol       <= TOL_RESET;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_ang  <= '0;
            r_first_ang <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_tol       <= n_tol;
            r_first_x   <= n_first_x;
            r_first_y   <= n_first_y;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_prev_ang  <= n_prev_ang;
            r_first_ang <= n_first_ang;
            r_out_valid <= n_out_valid;
        end
        r_cur_x      <= n_cur_x;
        r_cur_y      <= n_cur_y;
        r_cur_last   <= n_cur_last;
        r_seg_ang    <= n_seg_ang;
        r_close_ang  <= n_close_ang;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_corner <= n_out_corner;
        r_out_end    <= n_out_end;
    end

    assign o_pt_ready       = (r_state == S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_res_valid      = r_out_valid;
    assign o_corner_x       = r_out_x;
    assign o_corner_y       = r_out_y;
    assign o_is_corner      = r_out_corner;
    assign o_end_of_contour = r_out_end;

endmodule

@@ src/cradc_cordic.sv @@
// ----------------------------------------------------------------------------
// cradc_cordic
// segment slope angle by iterative vectoring arctangent, one iteration a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cradc_cordic
    import cradc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_seg_req i_req,
    output t_seg_rsp o_rsp
);

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_ITERS = 16;
    localparam int ITER_BITS    = $clog2(CORDIC_ITERS);
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int XY_BITS      = COORD_BITS + FRAC_BITS + 3;
    localparam int Z_BITS       = 24;
    localparam int ATAN_BITS    = 22;
    localparam int MAG_BITS     = Z_BITS - 9;
    localparam logic signed [Z_BITS-1:0] Z_MAX   = 24'sd5898240;
    localparam logic signed [Z_BITS-1:0] Z_ROUND = 24'sd128;
    localparam logic [ITER_BITS-1:0]     ITER_LAST = ITER_BITS'(CORDIC_ITERS - 1);

    function automatic logic [ATAN_BITS-1:0] atan_q16(input logic [ITER_BITS-1:0] idx);
        logic [ATAN_BITS-1:0] v;
        unique case (idx)
            4'd0:  v = 22'd2949120;
            4'd1:  v = 22'd1740967;
            4'd2:  v = 22'd919879;
            4'd3:  v = 22'd466945;
            4'd4:  v = 22'd234379;
            4'd5:  v = 22'd117304;
            4'd6:  v = 22'd58666;
            4'd7:  v = 22'd29335;
            4'd8:  v = 22'd14668;
            4'd9:  v = 22'd7334;
            4'd10: v = 22'd3667;
            4'd11: v = 22'd1833;
            4'd12: v = 22'd917;
            4'd13: v = 22'd458;
            4'd14: v = 22'd229;
            4'd15: v = 22'd115;
        endcase
        return v;
    endfunction

    logic                        r_busy, n_busy;
    logic                        r_fin, n_fin;
    logic                        r_done, n_done;
    logic [ITER_BITS-1:0]        r_iter, n_iter;
    logic signed [XY_BITS-1:0]   r_x, n_x;
    logic signed [XY_BITS-1:0]   r_y, n_y;
    logic signed [Z_BITS-1:0]    r_z, n_z;
    logic                        r_neg, n_neg;
    logic                        r_vert, n_vert;
    logic                        r_flat, n_flat;
    logic signed [ANG_BITS-1:0]  r_angle, n_angle;

    logic signed [DIFF_BITS-1:0] w_dx, w_dy;
    logic [DIFF_BITS-1:0]        w_adx, w_ady;
    logic signed [XY_BITS-1:0]   w_xs, w_ys;
    logic signed [Z_BITS-1:0]    w_step;
    logic signed [Z_BITS-1:0]    w_zc, w_zr;
    logic [MAG_BITS-1:0]         w_mag;
    logic signed [ANG_BITS-1:0]  w_smag;

    assign w_dx  = signed'({1'b0, i_req.ax}) - signed'({1'b0, i_req.bx});
    assign w_dy  = signed'({1'b0, i_req.ay}) - signed'({1'b0, i_req.by});
    assign w_adx = w_dx[DIFF_BITS-1] ? DIFF_BITS'(-w_dx) : DIFF_BITS'(w_dx);
    assign w_ady = w_dy[DIFF_BITS-1] ? DIFF_BITS'(-w_dy) : DIFF_BITS'(w_dy);

    assign w_xs   = r_x >>> r_iter;
    assign w_ys   = r_y >>> r_iter;
    assign w_step = signed'(Z_BITS'(atan_q16(r_iter)));

    always_comb begin
        if (r_z < 0) begin
            w_zc = '0;
        end else if (r_z > Z_MAX) begin
            w_zc = Z_MAX;
        end else begin
            w_zc = r_z;
        end
        w_zr   = w_zc + Z_ROUND;
        w_mag  = w_zr[Z_BITS-2:8];
        w_smag = signed'({1'b0, w_mag});
    end

    always_comb begin
        n_busy  = r_busy;
        n_fin   = 1'b0;
        n_done  = 1'b0;
        n_iter  = r_iter;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_neg   = r_neg;
        n_vert  = r_vert;
        n_flat  = r_flat;
        n_angle = r_angle;

        if (i_req.start) begin
            n_busy = 1'b1;
            n_iter = '0;
            n_x    = signed'(XY_BITS'({w_adx[COORD_BITS-1:0], {FRAC_BITS{1'b0}}}));
            n_y    = signed'(XY_BITS'({w_ady[COORD_BITS-1:0], {FRAC_BITS{1'b0}}}));
            n_z    = '0;
            n_neg  = w_dx[DIFF_BITS-1] ^ w_dy[DIFF_BITS-1];
            n_vert = (w_dx == '0);
            n_flat = (w_dy == '0);
        end else if (r_busy) begin
            if (!r_y[XY_BITS-1]) begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_step;
            end else begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_step;
            end
            if (r_iter == ITER_LAST) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end else begin
                n_iter = r_iter + 1'b1;
            end
        end else if (r_fin) begin
            n_done = 1'b1;
            if (r_vert) begin
                n_angle = RIGHT_Q8;
            end else if (r_flat) begin
                n_angle = '0;
            end else if (r_neg) begin
                n_angle = -w_smag;
            end else begin
                n_angle = w_smag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
            r_iter <= n_iter;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_neg   <= n_neg;
        r_vert  <= n_vert;
        r_flat  <= n_flat;
        r_angle <= n_angle;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.angle = r_angle;

endmodule

@@ src/cradc_checker.sv @@
// ----------------------------------------------------------------------------
// cradc_checker
// port-level checks of the contour corner detector, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "contour_right_angle_corner_detect_assert.svh"

module cradc_checker
    import cradc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_res_valid,
    input logic                  i_res_ready,
    input logic [COORD_BITS-1:0] o_corner_x,
    input logic [COORD_BITS-1:0] o_corner_y,
    input logic                  o_is_corner,
    input logic                  o_end_of_contour
);

    // a result beat is either a corner or the end marker, never both
    `CRADC_ASSERT_NOW(a_kind_onehot, o_res_valid, o_is_corner != o_end_of_contour, "result kind is not one-hot")

    // end marker carries zero coordinates
    `CRADC_ASSERT_NOW(a_marker_zero, o_res_valid && o_end_of_contour, (o_corner_x == '0) && (o_corner_y == '0), "end marker with nonzero coordinates")

    // stalled result beat holds
    `CRADC_ASSERT_NEXT(a_res_hold, o_res_valid && !i_res_ready, o_res_valid && $stable(o_corner_x) && $stable(o_corner_y) && $stable(o_is_corner) && $stable(o_end_of_contour), "stalled result changed")

    // nothing pending right after reset
    `CRADC_ASSERT_NOW(a_reset_empty, $past(!i_rst_n), !o_res_valid, "result valid right after reset")

endmodule

bind contour_right_angle_corner_detect cradc_checker u_cradc_checker (.*);

@@ sim/tb_contour_right_angle_corner_detect.sv @@
// ----------------------------------------------------------------------------
// tb_contour_right_angle_corner_detect
// self-checking bench for the contour right-angle corner detector: a directed
// table of short contours, then random closed contours (right-angle walks,
// exact rectangles, scattered and clustered points) under several tolerance
// settings and idle patterns; every result beat is checked against a typed
// expected table or a bit-exact corner predictor with its own fixed-point arctangent
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_contour_right_angle_corner_detect;
    import cradc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 48;
    localparam int HOLD_CYCLES    = 300;
    localparam int DIR_ROWS       = 22;
    localparam int TYPED_ROWS     = 8;
    localparam int N_PHASES       = 6;
    localparam int TOL_RANDOM     = -1;

    localparam longint ATAN_Q16 [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    localparam int PH_TOL   [N_PHASES] = '{0, 90, TOL_RANDOM, TOL_RANDOM, 95, 20};
    localparam int PH_SEND  [N_PHASES] = '{0, 74, 0, 31, 0, 31};
    localparam int PH_RECV  [N_PHASES] = '{0, 0, 74, 31, 0, 31};
    localparam int PH_ITEMS [N_PHASES] = '{80, 80, 80, 80, 50, 60};

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  is_corner;
        logic                  eoc;
    } t_corner;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last;
        logic                  typed;
        logic [2:0]            n_typed;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_pt_valid;
    logic                  o_pt_ready;
    logic [COORD_BITS-1:0] i_point_x;
    logic [COORD_BITS-1:0] i_point_y;
    logic                  i_last_point;
    logic                  o_res_valid;
    logic                  i_res_ready;
    logic [COORD_BITS-1:0] o_corner_x;
    logic [COORD_BITS-1:0] o_corner_y;
    logic                  o_is_corner;
    logic                  o_end_of_contour;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [TOL_BITS-1:0]   i_cfg_angle_tolerance;

    contour_right_angle_corner_detect dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_pt_valid            (i_pt_valid),
        .o_pt_ready            (o_pt_ready),
        .i_point_x             (i_point_x),
        .i_point_y             (i_point_y),
        .i_last_point          (i_last_point),
        .o_res_valid           (o_res_valid),
        .i_res_ready           (i_res_ready),
        .o_corner_x            (o_corner_x),
        .o_corner_y            (o_corner_y),
        .o_is_corner           (o_is_corner),
        .o_end_of_contour      (o_end_of_contour),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_angle_tolerance (i_cfg_angle_tolerance)
    );

    // predictor state
    logic [TOL_BITS-1:0]        tol_deg;
    logic [COORD_BITS-1:0]      cont_first_x, cont_first_y, prev_x, prev_y;
    logic signed [ANG_BITS-1:0] last_seg_ang, first_seg_ang;
    int                         pts_count;

    t_corner  corner_q [$];
    t_corner  step_res [$];
    t_dir_row dir_rows [DIR_ROWS];
    t_corner  typed_res [TYPED_ROWS];
    int       typed_pos;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int stall_cycles;
    int fail_count;
    int n_points, n_contours, n_beats, n_corners, n_tol_writes;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [ANG_BITS-1:0] seg_slope(
        input logic [COORD_BITS-1:0] ax, ay, bx, by
    );
        int                         dx, dy;
        longint                     cx, cy, cz, xs, ys;
        logic signed [ANG_BITS-1:0] mag;
        dx = int'(ax) - int'(bx);
        dy = int'(ay) - int'(by);
        if (dx == 0) return RIGHT_Q8;
        if (dy == 0) return '0;
        cx = longint'(dx < 0 ? -dx : dx) * 65536;
        cy = longint'(dy < 0 ? -dy : dy) * 65536;
        cz = 0;
        for (int i = 0; i < 16; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy >= 0) begin
                cx = cx + ys;
                cy = cy - xs;
                cz = cz + ATAN_Q16[i];
            end else begin
                cx = cx - ys;
                cy = cy + xs;
                cz = cz - ATAN_Q16[i];
            end
        end
        if (cz < 0) cz = 0;
        if (cz > 64'sd90 * 65536) cz = 64'sd90 * 65536;
        mag = ANG_BITS'((cz + 128) >>> 8);
        return ((dx < 0) != (dy < 0)) ? -mag : mag;
    endfunction

    function automatic bit near_right(input logic signed [ANG_BITS-1:0] a1, a2);
        int d;
        int tol;
        d   = int'(a2) - int'(a1);
        tol = int'(tol_deg);
        if (d < 0) d = -d;
        return (d >= (90 - tol) * 256) && (d <= (90 + tol) * 256);
    endfunction

    task automatic clear_contour();
        cont_first_x  = '0;
        cont_first_y  = '0;
        prev_x        = '0;
        prev_y        = '0;
        last_seg_ang  = '0;
        first_seg_ang = '0;
        pts_count     = 0;
    endtask

    // expected results of one point go to step_res
    task automatic predict_corners(
        input logic [COORD_BITS-1:0] px, py, input logic last
    );
        logic signed [ANG_BITS-1:0] a, a_close;
        if (pts_count == 0) begin
            cont_first_x = px;
            cont_first_y = py;
            pts_count    = 1;
        end else begin
            a = seg_slope(prev_x, prev_y, px, py);
            if (pts_count == 1) begin
                first_seg_ang = a;
                pts_count     = 2;
            end else begin
                if (near_right(last_seg_ang, a))
                    step_res.insert(step_res.size(),
                                    t_corner'({prev_x, prev_y, 1'b1, 1'b0}));
                pts_count = 3;
            end
            last_seg_ang = a;
        end
        prev_x = px;
        prev_y = py;
        if (last) begin
            if (pts_count == 3) begin
                a_close = seg_slope(px, py, cont_first_x, cont_first_y);
                if (near_right(last_seg_ang, a_close))
                    step_res.insert(step_res.size(), t_corner'({px, py, 1'b1, 1'b0}));
                if (near_right(a_close, first_seg_ang))
                    step_res.insert(step_res.size(),
                                    t_corner'({cont_first_x, cont_first_y, 1'b1, 1'b0}));
            end
            step_res.insert(step_res.size(),
                t_corner'({{COORD_BITS{1'b0}}, {COORD_BITS{1'b0}}, 1'b0, 1'b1}));
            clear_contour();
        end
    endtask

    // called at a falling edge, returns at a falling edge; n_typed < 0 means predicted
    task automatic send_point(input int px, py, input bit last, input int n_typed);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 30) gap++;
        if (gap > 0) begin
            i_pt_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_pt_valid   <= 1'b1;
        i_point_x    <= px[COORD_BITS-1:0];
        i_point_y    <= py[COORD_BITS-1:0];
        i_last_point <= last;
        do @(posedge i_clk); while (!o_pt_ready);
        step_res.delete();
        predict_corners(px[COORD_BITS-1:0], py[COORD_BITS-1:0], last);
        if (n_typed < 0) begin
            foreach (step_res[k]) corner_q.insert(corner_q.size(), step_res[k]);
        end else begin
            for (int k = 0; k < n_typed; k++)
                corner_q.insert(corner_q.size(), typed_res[typed_pos++]);
        end
        n_points++;
        if (last) n_contours++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_pt_valid <= 1'b0;
        while (corner_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tolerance(input int tol);
        i_cfg_valid           <= 1'b1;
        i_cfg_angle_tolerance <= tol[TOL_BITS-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        tol_deg = tol[TOL_BITS-1:0];
        n_tol_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    // one closed contour of random shape
    task automatic send_contour(output int len);
        int shape, px, py, dx, dy, wx, wy, k, pick, pert;
        int rx [4];
        int ry [4];
        pick = $urandom_range(99);
        if (pick < 40) shape = 0;
        else if (pick < 65) shape = 1;
        else if (pick < 85) shape = 2;
        else shape = 3;
        len = ($urandom_range(99) < 15) ? $urandom_range(1, 2) : $urandom_range(3, 10);
        case (shape)
            0: begin
                // walk with mostly perpendicular turns
                px = $urandom_range(4095);
                py = $urandom_range(4095);
                dx = int'($urandom_range(800)) - 400;
                dy = int'($urandom_range(800)) - 400;
                for (k = 0; k < len; k++) begin
                    send_point(clamp_coord(px), clamp_coord(py), k == len - 1, -1);
                    pick = $urandom_range(9);
                    pert = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(16)) - 8;
                    if (pick < 5) begin
                        wx = dx;
                        dx = -dy + pert;
                        dy = wx + pert;
                    end else if (pick >= 7) begin
                        dx = int'($urandom_range(800)) - 400;
                        dy = int'($urandom_range(800)) - 400;
                    end
                    px = clamp_coord(px + dx);
                    py = clamp_coord(py + dy);
                end
            end
            1: begin
                // exact rectangle or three of its corners, possibly rotated
                px = $urandom_range(1200, 2895);
                py = $urandom_range(1200, 2895);
                dx = int'($urandom_range(800)) - 400;
                dy = int'($urandom_range(800)) - 400;
                pick = $urandom_range(1, 2);
                wx = -dy * pick;
                wy = dx * pick;
                rx = '{px, px + dx, px + dx + wx, px + wx};
                ry = '{py, py + dy, py + dy + wy, py + wy};
                len = ($urandom_range(3) == 0) ? 3 : 4;
                for (k = 0; k < len; k++) send_point(rx[k], ry[k], k == len - 1, -1);
            end
            2: begin
                for (k = 0; k < len; k++)
                    send_point($urandom_range(4095), $urandom_range(4095), k == len - 1, -1);
            end
            default: begin
                // tiny cluster: repeated points and small steps
                px = $urandom_range(4095 - 3);
                py = $urandom_range(4095 - 3);
                for (k = 0; k < len; k++)
                    send_point(px + $urandom_range(3), py + $urandom_range(3),
                               k == len - 1, -1);
            end
        endcase
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_res_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left   = hold_left - 1;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin : res_check
        t_corner got, want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            got = {o_corner_x, o_corner_y, o_is_corner, o_end_of_contour};
            n_beats++;
            if (got.is_corner) n_corners++;
            if (corner_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected beat: x=%0d y=%0d corner=%0b end=%0b",
                             got.x, got.y, got.is_corner, got.eoc);
            end else begin
                want = corner_q[0];
                corner_q.delete(0);
                if (got.x !== want.x || got.y !== want.y ||
                    got.is_corner !== want.is_corner || got.eoc !== want.eoc) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("beat %0d: exp %0d,%0d c=%0b e=%0b got %0d,%0d c=%0b e=%0b",
                                 n_beats, want.x, want.y, want.is_corner, want.eoc,
                                 got.x, got.y, got.is_corner, got.eoc);
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_pt_valid && o_pt_ready) || (o_res_valid && i_res_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     stall_cycles, corner_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int tol, sent, len;
        i_rst_n               = 1'b0;
        i_pt_valid            = 1'b0;
        i_point_x             = '0;
        i_point_y             = '0;
        i_last_point          = 1'b0;
        i_cfg_valid           = 1'b0;
        i_cfg_angle_tolerance = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        stall_cycles   = 0;
        fail_count     = 0;
        n_points       = 0;
        n_contours     = 0;
        n_beats        = 0;
        n_corners      = 0;
        n_tol_writes   = 0;
        typed_pos      = 0;
        tol_deg        = 7'd20;
        clear_contour();

        // x, y, last, typed, typed result count
        dir_rows = '{
            {12'd0,    12'd0,    1'b1, 1'b1, 3'd1},  // single point
            {12'd4095, 12'd4095, 1'b0, 1'b1, 3'd0},  // two points
            {12'd0,    12'd0,    1'b1, 1'b1, 3'd1},
            {12'd0,    12'd0,    1'b0, 1'b1, 3'd0},  // full-frame square
            {12'd4095, 12'd0,    1'b0, 1'b1, 3'd0},
            {12'd4095, 12'd4095, 1'b0, 1'b1, 3'd1},
            {12'd0,    12'd4095, 1'b1, 1'b1, 3'd4},
            {12'd0,    12'd0,    1'b0, 1'b1, 3'd0},  // straight line
            {12'd100,  12'd0,    1'b0, 1'b1, 3'd0},
            {12'd200,  12'd0,    1'b0, 1'b1, 3'd0},
            {12'd300,  12'd0,    1'b1, 1'b1, 3'd1},
            {12'd5,    12'd5,    1'b0, 1'b0, 3'd0},  // repeated points
            {12'd5,    12'd5,    1'b0, 1'b0, 3'd0},
            {12'd10,   12'd5,    1'b0, 1'b0, 3'd0},
            {12'd10,   12'd5,    1'b1, 1'b0, 3'd0},
            {12'd2048, 12'd0,    1'b0, 1'b0, 3'd0},  // diamond
            {12'd4095, 12'd2047, 1'b0, 1'b0, 3'd0},
            {12'd2048, 12'd4094, 1'b0, 1'b0, 3'd0},
            {12'd0,    12'd2047, 1'b1, 1'b0, 3'd0},
            {12'd0,    12'd0,    1'b0, 1'b0, 3'd0},  // triangle
            {12'd0,    12'd4095, 1'b0, 1'b0, 3'd0},
            {12'd4095, 12'd0,    1'b1, 1'b0, 3'd0}
        };
        typed_res = '{
            {12'd0,    12'd0,    1'b0, 1'b1},
            {12'd0,    12'd0,    1'b0, 1'b1},
            {12'd4095, 12'd0,    1'b1, 1'b0},
            {12'd4095, 12'd4095, 1'b1, 1'b0},
            {12'd0,    12'd4095, 1'b1, 1'b0},
            {12'd0,    12'd0,    1'b1, 1'b0},
            {12'd0,    12'd0,    1'b0, 1'b1},
            {12'd0,    12'd0,    1'b0, 1'b1}
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table at the reset tolerance
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_point(dir_rows[r].x, dir_rows[r].y, dir_rows[r].last,
                       dir_rows[r].typed ? int'(dir_rows[r].n_typed) : -1);
        end
        wait_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            tol = (PH_TOL[p] == TOL_RANDOM) ? $urandom_range(1, 89) : PH_TOL[p];
            write_tolerance(tol);
            send_idle_pct  = PH_SEND[p];
            recv_stall_pct = PH_RECV[p];
            // long output hold-off while points keep coming
            if (p == 0) hold_left = HOLD_CYCLES;
            sent = 0;
            while (sent < PH_ITEMS[p]) begin
                send_contour(len);
                sent = sent + len;
                // sender pause until everything is out
                if (p == 3 && sent >= PH_ITEMS[p] / 2 && sent - len < PH_ITEMS[p] / 2)
                    wait_idle();
            end
            wait_idle();
        end

        $display("covered %0d points in %0d contours over %0d tolerance settings",
                 n_points, n_contours, n_tol_writes + 1);
        $display("checked %0d result beats, %0d corners, %0d mismatches",
                 n_beats, n_corners, fail_count);
        if (fail_count == 0 && corner_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/cradc_pkg.sv
src/cradc_cordic.sv
src/contour_right_angle_corner_detect.sv
src/cradc_checker.sv
sim/tb_contour_right_angle_corner_detect.sv
